// ===== rtl/dpla_pkg.sv =====
// drum printer line assembler package: item types, controller states,
// controller/datapath command and status structs, glyph tables
// no dependencies
package dpla_pkg;

  localparam int unsigned LineLen  = 20;
  localparam int unsigned PosW     = 5;
  localparam int unsigned GlyphW   = 7;
  localparam int unsigned Sectors  = 13;
  localparam int unsigned SignTop  = 15;
  localparam int unsigned DigitCols = 15;

  localparam logic [GlyphW-1:0] SpaceCh = 7'h20;
  localparam logic [GlyphW-1:0] MinusCh = 7'h2d;

  typedef struct packed {
    logic [3:0]           sector_index;
    logic [DigitCols-1:0] digit_hammers;
    logic [1:0]           symbol_hammers;
    logic                 feed_pulse;
    logic                 red_ink;
  } in_item_t;

  typedef struct packed {
    logic [GlyphW-1:0] glyph;
    logic [PosW-1:0]   position;
    logic              last_char;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic ptr_scan;
    logic ptr_zero;
    logic ptr_dec;
    logic ptr_inc;
    logic put_sign;
    logic drop_sign;
    logic emit;
    logic clear_line;
  } dp_cmd_t;

  typedef struct packed {
    logic feed;
    logic sign_go;
    logic at_space;
    logic ptr_first;
    logic ptr_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic [GlyphW-1:0] digit_glyph(input logic [3:0] sec);
    logic [7:0] c;
    case (sec)
      4'd0:    c = "0";
      4'd1:    c = "1";
      4'd2:    c = "2";
      4'd3:    c = "3";
      4'd4:    c = "4";
      4'd5:    c = "5";
      4'd6:    c = "6";
      4'd7:    c = "7";
      4'd8:    c = "8";
      4'd9:    c = "9";
      4'd10:   c = ".";
      4'd11:   c = ".";
      4'd12:   c = "-";
      default: c = " ";
    endcase
    return c[GlyphW-1:0];
  endfunction

  function automatic logic [GlyphW-1:0] sym17a_glyph(input logic [3:0] sec);
    logic [7:0] c;
    case (sec)
      4'd0:    c = "<";
      4'd5:    c = "M";
      4'd6:    c = "M";
      4'd9:    c = "S";
      default: c = " ";
    endcase
    return c[GlyphW-1:0];
  endfunction

  function automatic logic [GlyphW-1:0] sym17b_glyph(input logic [3:0] sec);
    logic [7:0] c;
    case (sec)
      4'd0:    c = ">";
      4'd1:    c = "+";
      4'd2:    c = "-";
      4'd3:    c = "x";
      4'd4:    c = "/";
      4'd5:    c = "+";
      4'd6:    c = "-";
      4'd7:    c = "^";
      4'd8:    c = "=";
      4'd9:    c = "q";
      4'd10:   c = "%";
      4'd11:   c = "C";
      4'd12:   c = "R";
      default: c = " ";
    endcase
    return c[GlyphW-1:0];
  endfunction

  function automatic logic [GlyphW-1:0] sym18a_glyph(input logic [3:0] sec);
    logic [7:0] c;
    case (sec)
      4'd5:    c = "M";
      4'd6:    c = "M";
      4'd10:   c = "E";
      default: c = " ";
    endcase
    return c[GlyphW-1:0];
  endfunction

  function automatic logic [GlyphW-1:0] sym18b_glyph(input logic [3:0] sec);
    logic [7:0] c;
    case (sec)
      4'd0:    c = "#";
      4'd1:    c = "*";
      4'd2:    c = "1";
      4'd3:    c = "2";
      4'd4:    c = "3";
      4'd5:    c = "+";
      4'd6:    c = "-";
      4'd7:    c = "T";
      4'd8:    c = "K";
      4'd9:    c = "E";
      4'd10:   c = "x";
      4'd11:   c = "C";
      4'd12:   c = "M";
      default: c = " ";
    endcase
    return c[GlyphW-1:0];
  endfunction

endpackage

// ===== rtl/dpla_ctrl.sv =====
// drum printer line assembler controller: idle / sign scan / line emit
// depends on dpla_pkg
module dpla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpla_pkg::dp_sts_t sts_i,
  output dpla_pkg::dp_cmd_t cmd_o
);

  dpla_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpla_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpla_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.feed) begin
          state_d = sts_i.sign_go ? dpla_pkg::ST_SCAN : dpla_pkg::ST_EMIT;
        end
      end
      dpla_pkg::ST_SCAN: begin
        if (sts_i.at_space || sts_i.ptr_first) begin
          state_d = dpla_pkg::ST_EMIT;
        end
      end
      dpla_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.ptr_last) begin
          state_d = dpla_pkg::ST_IDLE;
        end
      end
      default: state_d = dpla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dpla_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.feed) begin
          cmd_o.ptr_scan = sts_i.sign_go;
          cmd_o.ptr_zero = !sts_i.sign_go;
        end
      end
      dpla_pkg::ST_SCAN: begin
        if (sts_i.at_space) begin
          cmd_o.put_sign = 1'b1;
          cmd_o.ptr_zero = 1'b1;
        end else if (sts_i.ptr_first) begin
          cmd_o.drop_sign = 1'b1;
          cmd_o.ptr_zero  = 1'b1;
        end else begin
          cmd_o.ptr_dec = 1'b1;
        end
      end
      dpla_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.clear_line = sts_i.ptr_last;
          cmd_o.ptr_inc    = !sts_i.ptr_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/dpla_datapath.sv =====
// drum printer line assembler datapath: line store, pending sign,
// position pointer and output register
// depends on dpla_pkg
module dpla_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpla_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpla_pkg::out_item_t out_item_o,
  input  dpla_pkg::dp_cmd_t   cmd_i,
  output dpla_pkg::dp_sts_t   sts_o
);

  logic [dpla_pkg::GlyphW-1:0] line_q [dpla_pkg::LineLen];
  logic                        pending_q;
  logic [dpla_pkg::PosW-1:0]   ptr_q;
  logic                        out_valid_q;
  dpla_pkg::out_item_t         out_q;
  logic                        print_ok;
  logic [dpla_pkg::GlyphW-1:0] cur_glyph;

  assign print_ok  = cmd_i.take && !in_item_i.feed_pulse &&
                     (in_item_i.sector_index < 4'(dpla_pkg::Sectors));
  assign cur_glyph = line_q[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dpla_pkg::LineLen; k++) begin
        line_q[k] <= dpla_pkg::SpaceCh;
      end
    end else if (cmd_i.clear_line) begin
      for (int k = 0; k < dpla_pkg::LineLen; k++) begin
        line_q[k] <= dpla_pkg::SpaceCh;
      end
    end else if (cmd_i.put_sign) begin
      line_q[ptr_q] <= dpla_pkg::MinusCh;
    end else if (print_ok) begin
      for (int k = 0; k < dpla_pkg::DigitCols; k++) begin
        if (in_item_i.digit_hammers[k]) begin
          line_q[k+1] <= dpla_pkg::digit_glyph(in_item_i.sector_index);
        end
      end
      if (in_item_i.symbol_hammers[0]) begin
        line_q[16] <= dpla_pkg::sym17a_glyph(in_item_i.sector_index);
        line_q[17] <= dpla_pkg::sym17b_glyph(in_item_i.sector_index);
      end
      if (in_item_i.symbol_hammers[1]) begin
        line_q[18] <= dpla_pkg::sym18a_glyph(in_item_i.sector_index);
        line_q[19] <= dpla_pkg::sym18b_glyph(in_item_i.sector_index);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (cmd_i.put_sign || cmd_i.drop_sign) begin
      pending_q <= 1'b0;
    end else if (cmd_i.take && in_item_i.red_ink) begin
      pending_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_scan) begin
      ptr_q <= dpla_pkg::PosW'(dpla_pkg::SignTop);
    end else if (cmd_i.ptr_zero) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_dec) begin
      ptr_q <= ptr_q - 1'b1;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.glyph     <= cur_glyph;
      out_q.position  <= ptr_q;
      out_q.last_char <= sts_o.ptr_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    sts_o.feed      = in_item_i.feed_pulse;
    sts_o.sign_go   = in_item_i.red_ink || pending_q;
    sts_o.at_space  = (cur_glyph == dpla_pkg::SpaceCh);
    sts_o.ptr_first = (ptr_q == '0);
    sts_o.ptr_last  = (ptr_q == dpla_pkg::PosW'(dpla_pkg::LineLen - 1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ===== rtl/drum_printer_line_assembler.sv =====
// drum printer line assembler top level
// depends on dpla_pkg, dpla_ctrl, dpla_datapath
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_item_i) takes one drum-sector
//   sample per item. a sample without feed stores glyphs for the fired
//   hammers into the 20-character line; it gives no result. red ink marks
//   a pending sign until the next feed.
//   a sample with feed flushes the line: if a sign is pending or the feed
//   sample has red ink, the sign search walks positions 15 down to 0, one
//   per cycle, then twenty characters leave on the out channel
//   (out_valid_o / out_ready_i / out_item_o), one per cycle while the
//   receiver is ready, position 19 flagged last. a feed item occupies the
//   block while the pointer walks the line store. in_ready_o is high only
//   while no feed is in progress.
//   the output register holds a character while the receiver stalls; the
//   walk waits with it, and the next item is taken as soon as the last
//   character sits in the output register.
//   reset fills the line store with spaces, clears the pending sign and
//   empties the output register.
module drum_printer_line_assembler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dpla_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpla_pkg::out_item_t out_item_o
);

  dpla_pkg::dp_cmd_t cmd;
  dpla_pkg::dp_sts_t sts;

  dpla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpla_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
